[design/pfrt_pkg.sv]
`default_nettype none

package pfrt_pkg;

    // Default sizes of the block.
    localparam int COORD_WIDTH_DEF   = 24;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Inner angle format: one turn is 2^TURN_W units.
    localparam int TURN_W = 32;

    // Inverse CORDIC gain in Q0.16, about 0.6072529.
    localparam logic [15:0] KINV_Q16 = 16'd39797;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_PREV_ORIGIN_X = 3'd0,
        REG_PREV_ORIGIN_Y = 3'd1,
        REG_PREV_ANGLE    = 3'd2,
        REG_NEW_ORIGIN_X  = 3'd3,
        REG_NEW_ORIGIN_Y  = 3'd4,
        REG_NEW_ANGLE     = 3'd5
    } t_reg_index;

    // atan(2^-i) in 2^-32 turn units.
    function automatic logic [TURN_W-1:0] atan_turn(input int idx);
        logic [TURN_W-1:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[design/point_frame_rotate_translate_unit.sv]
`default_nettype none

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-------------------------------------
// in       | input     | i_in_valid / o_in_stall   | i_point_x, i_point_y
// out      | output    | o_out_valid / i_out_stall | o_result_x, o_result_y, o_saturated
// cfg      | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One point enters per cycle while the input does not stall; the stages are capture, multiply,
// quarter turn, one register per CORDIC stage, rounding, origin add with saturation.
// The depth is set by the chain of CORDIC micro-rotation stages.
// Reset is synchronous and active low; it clears all valid bits and the configuration registers.
// A stall on the output fills empty stages first; input stalls only when the pipe is full.

module point_frame_rotate_translate_unit #(
    parameter int COORD_WIDTH   = pfrt_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = pfrt_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = pfrt_pkg::CORDIC_STAGES_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [2:0]                           i_cfg_index,
    input  wire  [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0] i_cfg_data,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  signed [COORD_WIDTH-1:0]        i_point_x,
    input  wire  signed [COORD_WIDTH-1:0]        i_point_y,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic signed [COORD_WIDTH-1:0]        o_result_x,
    output logic signed [COORD_WIDTH-1:0]        o_result_y,
    output logic                                 o_saturated
);
    import pfrt_pkg::*;

    localparam int DW = COORD_WIDTH + 1;     // difference vector
    localparam int MW = COORD_WIDTH + 18;    // scaled by the inverse gain
    localparam int CW = COORD_WIDTH + 20;    // CORDIC datapath
    localparam int RW = CW - 16;             // after rounding off the guard bits
    localparam int SW = COORD_WIDTH + 5;     // origin sum
    localparam int N  = CORDIC_STAGES;

    localparam logic signed [MW-1:0]     KINV_S  = signed'(MW'(KINV_Q16));
    localparam logic [TURN_W-1:0]        Q_HALF  = 32'h2000_0000;
    localparam logic signed [CW-1:0]     RND_ADD = CW'(32768);
    localparam logic signed [SW-1:0]     SAT_HI  = {{6{1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0]     SAT_LO  = {{6{1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    // Configuration registers.
    logic signed [COORD_WIDTH-1:0] r_prev_ox;
    logic signed [COORD_WIDTH-1:0] r_prev_oy;
    logic        [ANGLE_WIDTH-1:0] r_prev_ang;
    logic signed [COORD_WIDTH-1:0] r_new_ox;
    logic signed [COORD_WIDTH-1:0] r_new_oy;
    logic        [ANGLE_WIDTH-1:0] r_new_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ox  <= '0;
            r_prev_oy  <= '0;
            r_prev_ang <= '0;
            r_new_ox   <= '0;
            r_new_oy   <= '0;
            r_new_ang  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_PREV_ORIGIN_X: r_prev_ox  <= i_cfg_data[COORD_WIDTH-1:0];
                REG_PREV_ORIGIN_Y: r_prev_oy  <= i_cfg_data[COORD_WIDTH-1:0];
                REG_PREV_ANGLE:    r_prev_ang <= i_cfg_data[ANGLE_WIDTH-1:0];
                REG_NEW_ORIGIN_X:  r_new_ox   <= i_cfg_data[COORD_WIDTH-1:0];
                REG_NEW_ORIGIN_Y:  r_new_oy   <= i_cfg_data[COORD_WIDTH-1:0];
                REG_NEW_ANGLE:     r_new_ang  <= i_cfg_data[ANGLE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Load enables of the register stages; each is free when empty or draining.
    logic ld_s0, ld_s1, ld_rd, ld_o;
    logic [N+1:0] c_ld;

    // Stage 0: point minus previous origin, and the angle difference.
    logic                   r_s0_valid;
    logic signed [DW-1:0]   r_dx;
    logic signed [DW-1:0]   r_dy;
    logic [ANGLE_WIDTH-1:0] r_dz;

    assign ld_s0      = !r_s0_valid || ld_s1;
    assign o_in_stall = !ld_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (ld_s0) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_s0 && i_in_valid) begin
            r_dx <= DW'(i_point_x) - DW'(r_prev_ox);
            r_dy <= DW'(i_point_y) - DW'(r_prev_oy);
            r_dz <= r_new_ang - r_prev_ang;
        end
    end

    // Stage 1: inverse-gain multiply, and split of the angle into quarter and residual.
    logic                     r_s1_valid;
    logic signed [MW-1:0]     r_mx;
    logic signed [MW-1:0]     r_my;
    logic [1:0]               r_q;
    logic signed [TURN_W-1:0] r_r;
    logic [TURN_W-1:0]        w_z32;
    logic [TURN_W-1:0]        w_zq;
    logic [1:0]               w_q;
    logic [TURN_W-1:0]        w_res;

    always_comb begin
        w_z32 = TURN_W'(r_dz) << (TURN_W - ANGLE_WIDTH);
        w_zq  = w_z32 + Q_HALF;
        w_q   = w_zq[TURN_W-1:TURN_W-2];
        w_res = w_z32 - {w_q, {(TURN_W-2){1'b0}}};
    end

    assign ld_s1 = !r_s1_valid || c_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (ld_s1) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_s1 && r_s0_valid) begin
            r_mx <= MW'(r_dx) * KINV_S;
            r_my <= MW'(r_dy) * KINV_S;
            r_q  <= w_q;
            r_r  <= signed'(w_res);
        end
    end

    // CORDIC chain; index 0 is the exact quarter-turn stage.
    logic [N:0]               c_valid;
    logic signed [CW-1:0]     c_x [N+1];
    logic signed [CW-1:0]     c_y [N+1];
    logic signed [TURN_W-1:0] c_r [N+1];
    logic signed [CW-1:0]     w_ex;
    logic signed [CW-1:0]     w_ey;
    logic signed [CW-1:0]     n_qx;
    logic signed [CW-1:0]     n_qy;
    logic                     r_q_valid;
    logic signed [CW-1:0]     r_qx;
    logic signed [CW-1:0]     r_qy;
    logic signed [TURN_W-1:0] r_qr;

    // Quarter-turn rotation by swap and negate.
    always_comb begin
        w_ex = CW'(r_mx);
        w_ey = CW'(r_my);
        case (r_q)
            2'd1: begin
                n_qx = -w_ey;
                n_qy = w_ex;
            end
            2'd2: begin
                n_qx = -w_ex;
                n_qy = -w_ey;
            end
            2'd3: begin
                n_qx = w_ey;
                n_qy = -w_ex;
            end
            default: begin
                n_qx = w_ex;
                n_qy = w_ey;
            end
        endcase
    end

    assign c_ld[0] = !r_q_valid || c_ld[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (c_ld[0]) begin
            r_q_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ld[0] && r_s1_valid) begin
            r_qx <= n_qx;
            r_qy <= n_qy;
            r_qr <= r_r;
        end
    end

    assign c_valid[0] = r_q_valid;
    assign c_x[0]     = r_qx;
    assign c_y[0]     = r_qy;
    assign c_r[0]     = r_qr;

    // Micro-rotation stages.
    for (genvar i = 0; i < N; i++) begin : g_cordic
        pfrt_cordic_stage #(
            .CW    (CW),
            .SHIFT (i)
        ) u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_valid     (c_valid[i]),
            .i_x         (c_x[i]),
            .i_y         (c_y[i]),
            .i_r         (c_r[i]),
            .i_load_next (c_ld[i+2]),
            .o_load      (c_ld[i+1]),
            .o_valid     (c_valid[i+1]),
            .o_x         (c_x[i+1]),
            .o_y         (c_y[i+1]),
            .o_r         (c_r[i+1])
        );
    end

    assign c_ld[N+1] = ld_rd;

    // Rounding off the sixteen guard bits.
    logic                 r_rd_valid;
    logic signed [RW-1:0] r_rd_x;
    logic signed [RW-1:0] r_rd_y;
    logic signed [CW-1:0] w_rnd_x;
    logic signed [CW-1:0] w_rnd_y;

    assign w_rnd_x = c_x[N] + RND_ADD;
    assign w_rnd_y = c_y[N] + RND_ADD;
    assign ld_rd   = !r_rd_valid || ld_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (ld_rd) begin
            r_rd_valid <= c_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_rd && c_valid[N]) begin
            r_rd_x <= w_rnd_x[CW-1:16];
            r_rd_y <= w_rnd_y[CW-1:16];
        end
    end

    // New origin add and clamp into the coordinate range.
    logic                          r_o_valid;
    logic signed [COORD_WIDTH-1:0] r_o_x;
    logic signed [COORD_WIDTH-1:0] r_o_y;
    logic                          r_o_sat;
    logic signed [SW-1:0]          w_sum_x;
    logic signed [SW-1:0]          w_sum_y;
    logic signed [COORD_WIDTH-1:0] n_o_x;
    logic signed [COORD_WIDTH-1:0] n_o_y;
    logic                          n_o_sat;

    always_comb begin
        w_sum_x = SW'(r_rd_x) + SW'(r_new_ox);
        w_sum_y = SW'(r_rd_y) + SW'(r_new_oy);
        n_o_sat = 1'b0;
        n_o_x   = w_sum_x[COORD_WIDTH-1:0];
        n_o_y   = w_sum_y[COORD_WIDTH-1:0];
        if (w_sum_x > SAT_HI) begin
            n_o_x   = SAT_HI[COORD_WIDTH-1:0];
            n_o_sat = 1'b1;
        end else if (w_sum_x < SAT_LO) begin
            n_o_x   = SAT_LO[COORD_WIDTH-1:0];
            n_o_sat = 1'b1;
        end
        if (w_sum_y > SAT_HI) begin
            n_o_y   = SAT_HI[COORD_WIDTH-1:0];
            n_o_sat = 1'b1;
        end else if (w_sum_y < SAT_LO) begin
            n_o_y   = SAT_LO[COORD_WIDTH-1:0];
            n_o_sat = 1'b1;
        end
    end

    assign ld_o = !r_o_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ld_o) begin
            r_o_valid <= r_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_o && r_rd_valid) begin
            r_o_x   <= n_o_x;
            r_o_y   <= n_o_y;
            r_o_sat <= n_o_sat;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_result_x  = r_o_x;
    assign o_result_y  = r_o_y;
    assign o_saturated = r_o_sat;

`ifndef SYNTHESIS
    // Nothing comes out in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // The input stalls only when the first stage holds an item.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s0_valid)
        else $error("input stalled with an empty first stage");

    // An accepted point lands in the first stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_s0_valid)
        else $error("accepted point lost at the first stage");

    // A saturated result has a coordinate at one end of the range.
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_result_x == SAT_HI[COORD_WIDTH-1:0] || o_result_x == SAT_LO[COORD_WIDTH-1:0] ||
             o_result_y == SAT_HI[COORD_WIDTH-1:0] || o_result_y == SAT_LO[COORD_WIDTH-1:0]))
        else $error("saturation flag without a clamped coordinate");
`endif

endmodule

`default_nettype wire

[design/pfrt_cordic_stage.sv]
`default_nettype none

module pfrt_cordic_stage #(
    parameter int CW    = 44,
    parameter int SHIFT = 0
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    input  wire  signed [CW-1:0]              i_x,
    input  wire  signed [CW-1:0]              i_y,
    input  wire  signed [pfrt_pkg::TURN_W-1:0] i_r,
    input  wire                               i_load_next,
    output logic                              o_load,
    output logic                              o_valid,
    output logic signed [CW-1:0]              o_x,
    output logic signed [CW-1:0]              o_y,
    output logic signed [pfrt_pkg::TURN_W-1:0] o_r
);
    import pfrt_pkg::*;

    localparam logic signed [TURN_W-1:0] ATAN = signed'(atan_turn(SHIFT));

    logic                     r_valid;
    logic signed [CW-1:0]     r_x;
    logic signed [CW-1:0]     r_y;
    logic signed [TURN_W-1:0] r_r;
    logic signed [CW-1:0]     n_x;
    logic signed [CW-1:0]     n_y;
    logic signed [TURN_W-1:0] n_r;
    logic signed [CW-1:0]     w_xs;
    logic signed [CW-1:0]     w_ys;

    // The register takes new data when it is empty or its content moves on.
    assign o_load = !r_valid || i_load_next;

    // One micro-rotation toward the remaining angle.
    always_comb begin
        w_xs = i_x >>> SHIFT;
        w_ys = i_y >>> SHIFT;
        if (!i_r[TURN_W-1]) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_r = i_r - ATAN;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_r = i_r + ATAN;
        end
    end

    // Valid bit of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= i_valid;
        end
    end

    // Stage data, loaded only on a transfer.
    always_ff @(posedge i_clk) begin
        if (o_load && i_valid) begin
            r_x <= n_x;
            r_y <= n_y;
            r_r <= n_r;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_r     = r_r;

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import pfrt_pkg::*;

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int AW           = ANGLE_WIDTH_DEF;
    localparam int CFG_W        = (CW > AW) ? CW : AW;
    localparam int STAGES       = CORDIC_STAGES_DEF;
    localparam int PIPE_LATENCY = STAGES + 5;
    localparam int LONG_HOLD    = 120;
    localparam int PHASE_POINTS = 150;
    localparam int PHASES       = 12;

    localparam longint GAIN_INV_Q16 = 39797;
    localparam longint COORD_MAX    = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_MIN    = -(longint'(1) << (CW - 1));

    localparam logic [CW-1:0] PT_MAX = CW'(COORD_MAX);
    localparam logic [CW-1:0] PT_MIN = CW'(COORD_MIN);

    // Register indexes that decode to nothing.
    localparam logic [2:0] CFG_INDEX_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_INDEX_SPARE_HI = 3'd7;

    // Micro-rotation angles atan(2^-i) in 2^-32 turn units.
    localparam longint MICRO_TURN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // Angle steps around the quarter-turn boundaries, applied on top of a base angle.
    localparam logic [AW-1:0] ANGLE_BASE = 16'h1234;
    localparam logic [AW-1:0] TURN_STEPS [6] = '{
        16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'h1FFF, 16'hE000
    };

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_coord_pair;

    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          sat;
    } t_frame_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [2:0]           i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic signed [CW-1:0] i_point_x;
    logic signed [CW-1:0] i_point_y;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic signed [CW-1:0] o_result_x;
    logic signed [CW-1:0] o_result_y;
    logic                 o_saturated;

    // Frame settings as the block should hold them.
    logic signed [CW-1:0] prev_ox, prev_oy, new_ox, new_oy;
    logic [AW-1:0]        prev_ang, new_ang;

    t_coord_pair   points_to_send[$];
    t_frame_result predicted_points[$];
    t_coord_pair   next_pt;
    t_frame_result due;

    logic point_taken;
    logic hold_request;
    logic quiet;
    logic send_idle_on;
    int   send_gap;
    int   recv_gap;
    int   hold_left;
    int   error_count;
    int   points_sent;
    int   results_seen;
    int   saturated_seen;
    int   backpressure_cycles;
    int   frames_used;

    point_frame_rotate_translate_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result_x  (o_result_x),
        .o_result_y  (o_result_y),
        .o_saturated (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    // Maps one point from the previous frame into the new one.
    function automatic t_frame_result rotate_translate(logic signed [CW-1:0] px,
                                                       logic signed [CW-1:0] py);
        t_frame_result res;
        logic [AW-1:0] delta;
        logic [31:0]   turn, shifted, resid;
        logic [1:0]    quad;
        longint        vx, vy, swap, sx, sy, rem, ox, oy;
        delta   = new_ang - prev_ang;
        turn    = {delta, {(32 - AW){1'b0}}};
        shifted = turn + 32'h2000_0000;
        quad    = shifted[31:30];
        resid   = turn - {quad, 30'd0};
        rem     = longint'($signed(resid));
        vx = (longint'(px) - longint'(prev_ox)) * GAIN_INV_Q16;
        vy = (longint'(py) - longint'(prev_oy)) * GAIN_INV_Q16;

        // Exact quarter turns first, counter-clockwise.
        case (quad)
            2'd1: begin
                swap = vx; vx = -vy; vy = swap;
            end
            2'd2: begin
                vx = -vx; vy = -vy;
            end
            2'd3: begin
                swap = vx; vx = vy; vy = -swap;
            end
            default: ;
        endcase

        // Micro-rotations drive the residual angle toward zero.
        for (int k = 0; k < STAGES; k++) begin
            sx = vx >>> k;
            sy = vy >>> k;
            if (rem >= 0) begin
                vx = vx - sy; vy = vy + sx; rem = rem - MICRO_TURN[k];
            end else begin
                vx = vx + sy; vy = vy - sx; rem = rem + MICRO_TURN[k];
            end
        end

        // Round back to Q.8, add the new origin and clamp.
        ox = ((vx + 32768) >>> 16) + longint'(new_ox);
        oy = ((vy + 32768) >>> 16) + longint'(new_oy);
        res.sat = 1'b0;
        if (ox < COORD_MIN) begin ox = COORD_MIN; res.sat = 1'b1; end
        if (ox > COORD_MAX) begin ox = COORD_MAX; res.sat = 1'b1; end
        if (oy < COORD_MIN) begin oy = COORD_MIN; res.sat = 1'b1; end
        if (oy > COORD_MAX) begin oy = COORD_MAX; res.sat = 1'b1; end
        res.x = ox[CW-1:0];
        res.y = oy[CW-1:0];
        return res;
    endfunction

    // Coordinates weighted toward the extremes, zero and short values.
    function automatic logic [CW-1:0] pick_coord();
        logic [CW-1:0] v;
        int            offset;
        case ($urandom_range(0, 9))
            0: v = PT_MAX;
            1: v = PT_MIN;
            2: v = '0;
            3, 4: begin
                offset = int'($urandom_range(0, 8191)) - 4096;
                v = CW'(offset);
            end
            default: v = CW'($urandom());
        endcase
        return v;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PREV_ORIGIN_X: prev_ox  = value[CW-1:0];
            REG_PREV_ORIGIN_Y: prev_oy  = value[CW-1:0];
            REG_PREV_ANGLE:    prev_ang = value[AW-1:0];
            REG_NEW_ORIGIN_X:  new_ox   = value[CW-1:0];
            REG_NEW_ORIGIN_Y:  new_oy   = value[CW-1:0];
            REG_NEW_ANGLE:     new_ang  = value[AW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(logic [CFG_W-1:0] pox, logic [CFG_W-1:0] poy,
                             logic [CFG_W-1:0] pa, logic [CFG_W-1:0] nox,
                             logic [CFG_W-1:0] noy, logic [CFG_W-1:0] na);
        write_reg(REG_PREV_ORIGIN_X, pox);
        write_reg(REG_PREV_ORIGIN_Y, poy);
        write_reg(REG_PREV_ANGLE, pa);
        write_reg(REG_NEW_ORIGIN_X, nox);
        write_reg(REG_NEW_ORIGIN_Y, noy);
        write_reg(REG_NEW_ANGLE, na);
        frames_used++;
    endtask

    task automatic push_point(logic [CW-1:0] x, logic [CW-1:0] y);
        t_coord_pair pt;
        pt.x = x;
        pt.y = y;
        points_to_send.push_back(pt);
    endtask

    // Waits until every point is sent and every result has come back.
    // The check runs on the rising edge, where the driver's valid is already settled.
    task automatic wait_idle();
        while (points_to_send.size() != 0 || i_in_valid || predicted_points.size() != 0)
            @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(negedge i_clk);
    endtask

    // Input side: record each transfer and predict its result.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid) begin
            if (o_in_stall) begin
                backpressure_cycles++;
            end else begin
                predicted_points.push_back(rotate_translate(i_point_x, i_point_y));
                points_sent++;
                point_taken = 1'b1;
            end
        end
    end

    // Input driver: offers the next queued point, with random idle bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || point_taken) begin
            point_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (!quiet && send_idle_on && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 4);
                i_in_valid <= 1'b0;
            end else if (points_to_send.size() != 0) begin
                next_pt = points_to_send.pop_front();
                i_in_valid <= 1'b1;
                i_point_x  <= next_pt.x;
                i_point_y  <= next_pt.y;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output stall: random bursts, plus one long hold on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Output monitor: each transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (predicted_points.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result x=%0d y=%0d sat=%0d", $time,
                         o_result_x, o_result_y, o_saturated);
            end else begin
                due = predicted_points.pop_front();
                if (due.sat) saturated_seen++;
                if (o_result_x !== due.x) begin
                    error_count++;
                    $display("%0t: result_x expected %0d, got %0d", $time,
                             $signed(due.x), o_result_x);
                end
                if (o_result_y !== due.y) begin
                    error_count++;
                    $display("%0t: result_y expected %0d, got %0d", $time,
                             $signed(due.y), o_result_y);
                end
                if (o_saturated !== due.sat) begin
                    error_count++;
                    $display("%0t: saturated expected %0d, got %0d", $time,
                             due.sat, o_saturated);
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        logic [AW-1:0] target;
        t_coord_pair   pt;
        int            kind;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_point_x    = '0;
        i_point_y    = '0;
        i_out_stall  = 1'b0;
        point_taken  = 1'b0;
        hold_request = 1'b0;
        quiet        = 1'b0;
        send_idle_on = 1'b1;
        send_gap     = 0;
        recv_gap     = 0;
        hold_left    = 0;
        error_count  = 0;
        points_sent  = 0;
        results_seen = 0;
        saturated_seen      = 0;
        backpressure_cycles = 0;
        frames_used  = 1;
        prev_ox  = '0;
        prev_oy  = '0;
        new_ox   = '0;
        new_oy   = '0;
        prev_ang = '0;
        new_ang  = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset frame is the identity; writes to spare indexes must change nothing.
        write_reg(CFG_INDEX_SPARE_LO, CFG_W'($urandom()));
        write_reg(CFG_INDEX_SPARE_HI, CFG_W'($urandom()));
        push_point('0, '0);
        push_point(PT_MAX, PT_MAX);
        push_point(PT_MIN, PT_MIN);
        push_point(PT_MAX, PT_MIN);
        push_point(PT_MIN, PT_MAX);
        push_point(CW'(1), CW'(-1));
        wait_idle();

        // Opposite corner origins: a zero vector returns the new origin, the far corner
        // overflows. Angle upper bits are junk and the difference wraps.
        set_frame(PT_MIN, PT_MAX, {8'hA5, 16'hFFFF}, PT_MAX, PT_MIN, {8'h3C, 16'h0000});
        push_point(PT_MIN, PT_MAX);
        push_point(PT_MAX, PT_MIN);
        wait_idle();

        // Angle differences on and around the quarter-turn boundaries.
        foreach (TURN_STEPS[c]) begin
            target = ANGLE_BASE + TURN_STEPS[c];
            set_frame('0, '0, {8'h5A, ANGLE_BASE}, '0, '0, {8'hC3, target});
            push_point(CW'(100 * 256), CW'(-37 * 256));
            push_point(PT_MAX, '0);
            wait_idle();
        end

        // Random frames and points; phase two holds the output off for a long stretch.
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)
                set_frame(PT_MAX, PT_MAX, {8'hFF, 16'hFFFF}, PT_MAX, PT_MAX, '0);
            else if (p == 1)
                set_frame(PT_MIN, PT_MIN, '0, PT_MIN, PT_MIN, {8'hFF, 16'hFFFF});
            else
                set_frame(pick_coord(), pick_coord(), CFG_W'($urandom()),
                          pick_coord(), pick_coord(), CFG_W'($urandom()));
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? CFG_INDEX_SPARE_HI : CFG_INDEX_SPARE_LO,
                          CFG_W'($urandom()));
            send_idle_on = (p != 2);
            quiet = (p >= PHASES - 2);
            for (int n = 0; n < PHASE_POINTS; n++) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    pt.x = prev_ox;
                    pt.y = prev_oy;
                end else if (kind == 1) begin
                    pt.x = prev_ox ^ CW'($urandom_range(0, 15));
                    pt.y = prev_oy ^ CW'($urandom_range(0, 15));
                end else begin
                    pt.x = pick_coord();
                    pt.y = pick_coord();
                end
                points_to_send.push_back(pt);
            end
            if (p == 2) hold_request = 1'b1;
            wait_idle();
        end

        $display("Summary: %0d points over %0d frame settings, %0d results, %0d saturated.",
                 points_sent, frames_used, results_seen, saturated_seen);
        $display("Input was held back on %0d cycles during output holds.",
                 backpressure_cycles);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
